FILE: sv/ml127_pkg.sv
// Types and constants shared by the Mersenne-127 Lucas-Lehmer engine.
package ml127_pkg;

    localparam int RES_W      = 127;
    localparam int DIGIT_W    = 8;
    localparam int NUM_DIGITS = (RES_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int ACC_W      = RES_W + 2;
    localparam int PROD_W     = RES_W + DIGIT_W;
    localparam int STEP_W     = 8;

    localparam logic [RES_W-1:0] MOD_M = {RES_W{1'b1}};

    typedef struct packed {
        logic [62:0]       seed_hi;
        logic [63:0]       seed_lo;
        logic [STEP_W-1:0] step_count;
    } ll_in_t;

    typedef struct packed {
        logic [62:0] result_hi;
        logic [63:0] result_lo;
        logic        is_zero;
    } ll_out_t;

endpackage

FILE: sv/mersenne127_lucas_lehmer.sv
// Lucas-Lehmer iteration s <- s*s - 2 mod 2^127-1 with a digit-serial squarer.
//
// Pulse start while busy is low to hand in one word (seed and step count).
// Each step squares the residue with an 8 x 127 bit digit multiplier that
// walks the 16 digits of the residue, most significant first, one per cycle,
// then folds the sum in two steps (FOLD1, FOLD2) and subtracts two (SUB).
// done is registered and high for exactly one cycle after the last step's
// subtract (after the start itself for zero steps), with the canonical
// residue and its zero flag on result.
// The receiver cannot stall: the result word is valid only while done is
// high. busy falls in the same cycle, so the next start may be taken then.
module mersenne127_lucas_lehmer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ml127_pkg::ll_in_t item,
    output logic              busy,
    output logic              done,
    output ml127_pkg::ll_out_t result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_FOLD1 = 3'd2;
    localparam logic [2:0] ST_FOLD2 = 3'd3;
    localparam logic [2:0] ST_SUB   = 3'd4;

    localparam int RES_W   = ml127_pkg::RES_W;
    localparam int DIGIT_W = ml127_pkg::DIGIT_W;
    localparam int PAD_W   = ml127_pkg::PAD_W;
    localparam int CNT_W   = ml127_pkg::CNT_W;
    localparam int ACC_W   = ml127_pkg::ACC_W;
    localparam int PROD_W  = ml127_pkg::PROD_W;
    localparam int STEP_W  = ml127_pkg::STEP_W;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic              done_reg, done_next;
    logic [RES_W-1:0]  s_reg, s_next;
    logic [PAD_W-1:0]  dig_reg, dig_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    ml127_pkg::ll_out_t result_reg, result_next;

    logic [RES_W-1:0]   seed;
    logic [RES_W-1:0]   seed_red;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0]  prod;
    logic [RES_W-1:0]   acc_rot;
    logic [ACC_W-1:0]   acc_sum;
    logic [RES_W:0]     fold1;
    logic [RES_W-1:0]   fold2;
    logic [RES_W-1:0]   w_val;
    logic [RES_W-1:0]   sub_res;

    assign seed     = {item.seed_hi, item.seed_lo};
    assign seed_red = (seed == ml127_pkg::MOD_M) ? '0 : seed;

    // acc*2^8 mod M is a rotation of the low 127 bits; the two spill bits
    // above 2^127 fold to 2^8 and sit just above the product's fold bits.
    assign digit   = dig_reg[PAD_W-1 -: DIGIT_W];
    assign prod    = PROD_W'(digit) * PROD_W'(s_reg);
    assign acc_rot = {acc_reg[RES_W-1-DIGIT_W:0], acc_reg[RES_W-1 -: DIGIT_W]};
    assign acc_sum = {2'b00, acc_rot} + {2'b00, prod[RES_W-1:0]}
                   + ACC_W'({acc_reg[ACC_W-1 -: 2], prod[PROD_W-1 -: DIGIT_W]});

    assign fold1 = {1'b0, acc_reg[RES_W-1:0]} + (RES_W + 1)'(acc_reg[ACC_W-1 -: 2]);
    assign fold2 = acc_reg[RES_W-1:0] + RES_W'(acc_reg[RES_W]);

    // w may be M (all ones, same as zero); w - 2 still gives M - 2 there
    assign w_val   = acc_reg[RES_W-1:0];
    assign sub_res = (|w_val[RES_W-1:1]) ? (w_val - RES_W'(2))
                   : {{(RES_W-2){1'b1}}, (w_val[0] ? 2'b10 : 2'b01)};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        steps_next  = steps_reg;
        done_next   = 1'b0;
        s_next      = s_reg;
        dig_next    = dig_reg;
        acc_next    = acc_reg;
        result_next = result_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    s_next     = seed_red;
                    steps_next = item.step_count;
                    dig_next   = PAD_W'(seed_red);
                    acc_next   = '0;
                    cnt_next   = '0;
                    if (item.step_count == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = {seed_red, (seed_red == '0)};
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next = acc_sum;
                dig_next = {dig_reg[PAD_W-1-DIGIT_W:0], {DIGIT_W{1'b0}}};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ml127_pkg::NUM_DIGITS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FOLD1;
                end
            end
            ST_FOLD1:
            begin
                acc_next   = {1'b0, fold1};
                state_next = ST_FOLD2;
            end
            ST_FOLD2:
            begin
                acc_next   = {2'b00, fold2};
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                s_next     = sub_res;
                dig_next   = PAD_W'(sub_res);
                acc_next   = '0;
                steps_next = steps_reg - STEP_W'(1);
                if (steps_reg == STEP_W'(1))
                begin
                    done_next   = 1'b1;
                    result_next = {sub_res, (sub_res == '0)};
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            steps_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            steps_reg <= steps_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg      <= '0;
            dig_reg    <= '0;
            acc_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            s_reg      <= s_next;
            dig_reg    <= dig_next;
            acc_reg    <= acc_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a word comes out only from the last subtract or a zero-step start
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SUB ||
                       (state_reg == ST_IDLE && start && item.step_count == '0)))
        else $error("done without a finishing step");

    a_canonical: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({result.result_hi, result.result_lo} != ml127_pkg::MOD_M))
        else $error("result not canonical");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_zero == ({result.result_hi, result.result_lo} == '0)))
        else $error("zero flag mismatch");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (cnt_reg == '0))
        else $error("digit counter running outside multiply");

    a_steps_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (steps_reg != '0))
        else $error("multiply with no steps left");
`endif

endmodule
